[hw/rtl/cap_pkg.sv]
// shared constants, types and arctangent table for the circle arc point generator
`timescale 1ns / 1ps
package cap_pkg;

  // cordic depth and datapath widths
  localparam int ITERS     = 20;
  localparam int ZW        = 26;   // angle accumulator, 2^-24 turn units
  localparam int XW        = 34;   // rotation datapath
  localparam int VW        = 40;   // vectoring datapath
  localparam int CW        = 16;   // coordinate width
  localparam int DW        = 17;   // sums and differences of coordinates
  localparam int IW        = 6;    // point index width
  localparam int AW        = 24;   // angle modulo one turn
  localparam int MW        = 25;   // angle span magnitude
  localparam int RW        = 6;    // remainder of a division by the step count
  localparam int X0W       = 31;   // scaled radius fed to the rotator
  localparam int VEC_SHIFT = 20;   // vectoring input scaling

  localparam logic signed [ZW-1:0] HALF_TURN = 26'sd8388608;
  localparam logic [MW-1:0]        FULL_TURN = 25'd16777216;
  localparam logic [29:0]          INV_GAIN  = 30'd652032875;

  // arctan(2^-k) in 2^-24 turn units
  localparam logic signed [ZW-1:0] ATAN_TAB [ITERS] = '{
    26'sd2097152, 26'sd1238021, 26'sd654136, 26'sd332050, 26'sd166669,
    26'sd83416,   26'sd41718,   26'sd20860,  26'sd10430,  26'sd5215,
    26'sd2608,    26'sd1304,    26'sd652,    26'sd326,    26'sd163,
    26'sd81,      26'sd41,      26'sd20,     26'sd10,     26'sd5
  };

  // side data that travels with a point through the rotator
  typedef struct packed {
    logic                 valid;
    logic                 last;
    logic [IW-1:0]        index;
    logic                 flip;
    logic signed [DW-1:0] sum_x;
    logic signed [DW-1:0] sum_y;
  } rot_side_t;

  // per run parameters handed from setup to the point sequencer
  typedef struct packed {
    logic signed [DW-1:0] sum_x;
    logic signed [DW-1:0] sum_y;
    logic [X0W-1:0]       x0;
    logic [AW-1:0]        base;
    logic                 neg;
    logic [MW-1:0]        step_q;
    logic [RW-1:0]        step_r;
  } run_param_t;

endpackage

[hw/rtl/cap_vec_cell.sv]
// one vectoring cordic micro-rotation, registered
`timescale 1ns / 1ps
module cap_vec_cell
  import cap_pkg::*;
#(
  parameter int K = 0
) (
  input  logic                 clk,
  input  logic signed [VW-1:0] x_in,
  input  logic signed [VW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  output logic signed [VW-1:0] x_out,
  output logic signed [VW-1:0] y_out,
  output logic signed [ZW-1:0] z_out
);

  logic signed [VW-1:0] xs;
  logic signed [VW-1:0] ys;

  assign xs = x_in >>> K;
  assign ys = y_in >>> K;

  // drive y towards zero, accumulate the angle
  always_ff @(posedge clk) begin
    if (!y_in[VW-1]) begin
      x_out <= x_in + ys;
      y_out <= y_in - xs;
      z_out <= z_in + ATAN_TAB[K];
    end else begin
      x_out <= x_in - ys;
      y_out <= y_in + xs;
      z_out <= z_in - ATAN_TAB[K];
    end
  end

endmodule

[hw/rtl/cap_rot_cell.sv]
// one rotation cordic micro-rotation with stall and side data
`timescale 1ns / 1ps
module cap_rot_cell
  import cap_pkg::*;
#(
  parameter int K = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  input  rot_side_t            side_in,
  output logic signed [XW-1:0] x_out,
  output logic signed [XW-1:0] y_out,
  output logic signed [ZW-1:0] z_out,
  output rot_side_t            side_out
);

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;

  assign xs = x_in >>> K;
  assign ys = y_in >>> K;

  // drive the residual angle towards zero
  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else if (en) begin
      side_out <= side_in;
      if (!z_in[ZW-1]) begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - ATAN_TAB[K];
      end else begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + ATAN_TAB[K];
      end
    end
  end

endmodule

[hw/rtl/cap_setup.sv]
// per run setup: centre, radius square root, end angles and angle step
`timescale 1ns / 1ps
module cap_setup
  import cap_pkg::*;
#(
  parameter int POINT_STEPS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CW-1:0] p_x,
  input  logic signed [CW-1:0] p_y,
  input  logic signed [CW-1:0] q_x,
  input  logic signed [CW-1:0] q_y,
  input  logic                 full_circle,
  output logic                 par_valid,
  input  logic                 par_ready,
  output run_param_t           par
);

  localparam logic [30:0]   RECIP       = 31'((64'd1 << 32) / POINT_STEPS);
  localparam logic [MW-1:0] STEPS_M     = MW'(POINT_STEPS);
  localparam logic [60:0]   GAIN_ROUND  = 61'd1 << 29;
  localparam logic [5:0]    CNT_SQUARE  = 6'd0;
  localparam logic [5:0]    CNT_SQ_LOAD = 6'd1;
  localparam logic [5:0]    CNT_SQ_LAST = 6'd32;
  localparam logic [5:0]    CNT_GAIN    = 6'd33;
  localparam logic [5:0]    CNT_DONE    = 6'd34;
  localparam logic [5:0]    CNT_ANGLE   = 6'd21;
  localparam logic [5:0]    CNT_RECIP   = 6'd22;
  localparam logic [5:0]    CNT_QUOT    = 6'd23;
  localparam logic [5:0]    CNT_REM     = 6'd24;
  localparam logic [5:0]    CNT_FIX     = 6'd25;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
  } vec_t;

  logic                   busy;
  logic [5:0]             cnt;
  logic signed [DW-1:0]   dx;
  logic signed [DW-1:0]   dy;
  logic signed [DW-1:0]   sum_x;
  logic signed [DW-1:0]   sum_y;
  logic                   full;
  logic                   half;
  logic signed [2*DW-1:0] dx_w;
  logic signed [2*DW-1:0] dy_w;
  logic [31:0]            sq_x;
  logic [31:0]            sq_y;
  logic [61:0]            sq_in;
  logic [32:0]            rem;
  logic [30:0]            root;
  logic [34:0]            rem_sh;
  logic [34:0]            trial;
  logic [60:0]            prod_gain;
  logic signed [ZW-1:0]   t0;
  logic signed [ZW-1:0]   t1;
  logic signed [ZW:0]     span;
  logic [MW-1:0]          mag;
  logic                   neg;
  logic [AW-1:0]          base;
  logic [MW+30:0]         prod_div;
  logic [MW-1:0]          quot;
  logic [MW-1:0]          rem_d;
  logic [MW-1:0]          step_q;
  logic [RW-1:0]          step_r;
  vec_t                   ca [ITERS+1];
  vec_t                   cb [ITERS+1];

  // map a vector into the right half plane, scale it up
  function automatic vec_t vec_pre(input logic signed [DW:0] x, input logic signed [DW:0] y);
    vec_t               v;
    logic signed [DW:0] xa;
    logic signed [DW:0] ya;
    xa  = x;
    ya  = y;
    v.z = '0;
    if (x[DW]) begin
      v.z = y[DW] ? -HALF_TURN : HALF_TURN;
      xa  = -x;
      ya  = -y;
    end
    v.x = {{(VW-DW-1-VEC_SHIFT){xa[DW]}}, xa, {VEC_SHIFT{1'b0}}};
    v.y = {{(VW-DW-1-VEC_SHIFT){ya[DW]}}, ya, {VEC_SHIFT{1'b0}}};
    return v;
  endfunction

  assign in_ready  = !busy;
  assign par_valid = busy && (cnt == CNT_DONE);
  assign dx_w      = (2*DW)'(dx);
  assign dy_w      = (2*DW)'(dy);

  // control: busy flag and phase counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= CNT_SQUARE;
    end else if (in_valid && in_ready) begin
      busy <= 1'b1;
      cnt  <= CNT_SQUARE;
    end else if (par_valid && par_ready) begin
      busy <= 1'b0;
    end else if (busy && cnt != CNT_DONE) begin
      cnt <= cnt + 6'd1;
    end
  end

  // capture the transaction
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      dx    <= DW'(p_x) - DW'(q_x);
      dy    <= DW'(p_y) - DW'(q_y);
      sum_x <= DW'(p_x) + DW'(q_x);
      sum_y <= DW'(p_y) + DW'(q_y);
      full  <= full_circle;
      half  <= q_y < p_y;
    end
  end

  // vectoring chains for the angles of P and Q seen from the centre
  always_ff @(posedge clk) begin
    ca[0] <= vec_pre({dx[DW-1], dx}, {dy[DW-1], dy});
    cb[0] <= vec_pre(-{dx[DW-1], dx}, -{dy[DW-1], dy});
  end

  for (genvar k = 0; k < ITERS; k++) begin : g_vec
    cap_vec_cell #(.K(k)) u_cell_a (
      .clk  (clk),
      .x_in (ca[k].x), .y_in (ca[k].y), .z_in (ca[k].z),
      .x_out(ca[k+1].x), .y_out(ca[k+1].y), .z_out(ca[k+1].z)
    );
    cap_vec_cell #(.K(k)) u_cell_b (
      .clk  (clk),
      .x_in (cb[k].x), .y_in (cb[k].y), .z_in (cb[k].z),
      .x_out(cb[k+1].x), .y_out(cb[k+1].y), .z_out(cb[k+1].z)
    );
  end

  // square root, one result bit per cycle
  assign rem_sh = {rem, sq_in[61:60]};
  assign trial  = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (busy && cnt == CNT_SQUARE) begin
      sq_x <= 32'(dx_w * dx_w);
      sq_y <= 32'(dy_w * dy_w);
    end
    if (busy && cnt == CNT_SQ_LOAD) begin
      sq_in <= {1'b0, {1'b0, sq_x} + {1'b0, sq_y}, 28'b0};
      rem   <= '0;
      root  <= '0;
    end else if (busy && cnt > CNT_SQ_LOAD && cnt <= CNT_SQ_LAST) begin
      sq_in <= {sq_in[59:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= 33'(rem_sh - trial);
        root <= {root[29:0], 1'b1};
      end else begin
        rem  <= rem_sh[32:0];
        root <= {root[29:0], 1'b0};
      end
    end
    if (busy && cnt == CNT_GAIN) begin
      prod_gain <= root * INV_GAIN;
    end
  end

  // end angles and span
  assign t0   = (dx == '0 && dy == '0) ? '0 : ca[ITERS].z;
  assign t1   = (dx == '0 && dy == '0) ? '0 : cb[ITERS].z;
  assign span = {t1[ZW-1], t1} - {t0[ZW-1], t0};

  // angle step: span over the step count by reciprocal and one correction
  always_ff @(posedge clk) begin
    if (busy && cnt == CNT_ANGLE) begin
      mag  <= full ? FULL_TURN : MW'(span[ZW] ? -span : span);
      neg  <= !full && span[ZW];
      base <= full ? '0 : t0[AW-1:0] + (half ? AW'(HALF_TURN) : '0);
    end
    if (busy && cnt == CNT_RECIP) begin
      prod_div <= mag * RECIP;
    end
    if (busy && cnt == CNT_QUOT) begin
      quot <= MW'(prod_div[MW+30:32]);
    end
    if (busy && cnt == CNT_REM) begin
      rem_d <= mag - quot * STEPS_M;
    end
    if (busy && cnt == CNT_FIX) begin
      if (rem_d >= STEPS_M) begin
        step_q <= quot + MW'(1);
        step_r <= RW'(rem_d - STEPS_M);
      end else begin
        step_q <= quot;
        step_r <= RW'(rem_d);
      end
    end
  end

  // parameters for the run
  always_comb begin
    par.sum_x  = sum_x;
    par.sum_y  = sum_y;
    par.x0     = X0W'((prod_gain + GAIN_ROUND) >> 30);
    par.base   = base;
    par.neg    = neg;
    par.step_q = step_q;
    par.step_r = step_r;
  end

endmodule

[hw/rtl/circle_arc_point_generator.sv]
// circle arc point generator: setup, point sequencer, rotator chain, output register
`timescale 1ns / 1ps
// Each input transaction gives POINT_STEPS+1 points, one per cycle while the output side takes
// them. A bit-serial square root and the vectoring chain keep the setup unit busy for each
// transaction, overlapped with the previous run, so the block accepts a new transaction only
// after the setup unit has handed the parameters of the last one to the point sequencer.
// Points leave a 20-cell rotation chain. A stalled output holds the whole rotation chain.
module circle_arc_point_generator
  import cap_pkg::*;
#(
  parameter int POINT_STEPS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // p_x, p_y, q_x, q_y
  input  logic [0:0]  s_tuser,   // full_circle
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // point_x, point_y, point_index, zero fill
  output logic        m_tlast    // last_point
);

  localparam logic [IW-1:0]   STEPS_I   = IW'(POINT_STEPS);
  localparam logic [RW:0]     STEPS_R   = (RW+1)'(POINT_STEPS);
  localparam logic signed [20:0] COORD_MAX = 21'sd32767;
  localparam logic signed [20:0] COORD_MIN = -21'sd32768;

  logic                 par_valid;
  logic                 par_ready;
  run_param_t           par;
  run_param_t           cur;
  logic                 run;
  logic [IW-1:0]        idx;
  logic [MW-1:0]        acc_q;
  logic [RW-1:0]        acc_r;
  logic [RW:0]          r_sum;
  logic                 last_idx;
  logic                 adv;
  logic [AW-1:0]        angle;
  logic signed [XW-1:0] rx [ITERS+1];
  logic signed [XW-1:0] ry [ITERS+1];
  logic signed [ZW-1:0] rz [ITERS+1];
  rot_side_t            rs [ITERS+1];
  logic signed [XW-1:0] fx;
  logic signed [XW-1:0] fy;
  logic [CW-1:0]        out_x;
  logic [CW-1:0]        out_y;
  logic [IW-1:0]        out_idx;

  // rotated coordinate plus centre, rounded and saturated
  function automatic logic [CW-1:0] to_coord(input logic signed [XW-1:0] rot,
                                             input logic signed [DW-1:0] sum);
    logic signed [XW+1:0] t;
    logic signed [20:0]   v;
    t = {{2{rot[XW-1]}}, rot} + {{(XW+2-DW-14){sum[DW-1]}}, sum, 14'b0}
        + (XW+2)'(16384);
    v = t[XW+1:15];
    if (v > COORD_MAX) begin
      v = COORD_MAX;
    end else if (v < COORD_MIN) begin
      v = COORD_MIN;
    end
    return v[CW-1:0];
  endfunction

  cap_setup #(.POINT_STEPS(POINT_STEPS)) u_setup (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .p_x        (s_tdata[15:0]),
    .p_y        (s_tdata[31:16]),
    .q_x        (s_tdata[47:32]),
    .q_y        (s_tdata[63:48]),
    .full_circle(s_tuser[0]),
    .par_valid  (par_valid),
    .par_ready  (par_ready),
    .par        (par)
  );

  assign adv       = !m_tvalid || m_tready;
  assign last_idx  = idx == STEPS_I;
  assign par_ready = !run || (adv && last_idx);
  assign r_sum     = {1'b0, acc_r} + {1'b0, cur.step_r};
  assign angle     = cur.base + (cur.neg ? -acc_q[AW-1:0] : acc_q[AW-1:0]);

  // point sequencer: run flag
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else if (par_valid && par_ready) begin
      run <= 1'b1;
    end else if (run && adv && last_idx) begin
      run <= 1'b0;
    end
  end

  // point sequencer: index and angle accumulator
  always_ff @(posedge clk) begin
    if (par_valid && par_ready) begin
      cur   <= par;
      idx   <= '0;
      acc_q <= '0;
      acc_r <= '0;
    end else if (run && adv) begin
      idx <= idx + IW'(1);
      if (r_sum >= STEPS_R) begin
        acc_r <= RW'(r_sum - STEPS_R);
        acc_q <= acc_q + cur.step_q + MW'(1);
      end else begin
        acc_r <= RW'(r_sum);
        acc_q <= acc_q + cur.step_q;
      end
    end
  end

  // rotator entry: fold the angle into the right half plane
  always_ff @(posedge clk) begin
    if (rst) begin
      rs[0].valid <= 1'b0;
    end else if (adv) begin
      rx[0]       <= {{(XW-X0W){1'b0}}, cur.x0};
      ry[0]       <= '0;
      rs[0].valid <= run;
      rs[0].last  <= last_idx;
      rs[0].index <= idx;
      rs[0].sum_x <= cur.sum_x;
      rs[0].sum_y <= cur.sum_y;
      case (angle[AW-1:AW-2])
        2'b00: begin
          rz[0]      <= {2'b00, angle};
          rs[0].flip <= 1'b0;
        end
        2'b11: begin
          rz[0]      <= {2'b11, angle};
          rs[0].flip <= 1'b0;
        end
        default: begin
          rz[0]      <= {2'b00, angle} - HALF_TURN;
          rs[0].flip <= 1'b1;
        end
      endcase
    end
  end

  for (genvar k = 0; k < ITERS; k++) begin : g_rot
    cap_rot_cell #(.K(k)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .x_in    (rx[k]),
      .y_in    (ry[k]),
      .z_in    (rz[k]),
      .side_in (rs[k]),
      .x_out   (rx[k+1]),
      .y_out   (ry[k+1]),
      .z_out   (rz[k+1]),
      .side_out(rs[k+1])
    );
  end

  assign fx = rs[ITERS].flip ? -rx[ITERS] : rx[ITERS];
  assign fy = rs[ITERS].flip ? -ry[ITERS] : ry[ITERS];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= rs[ITERS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x   <= to_coord(fx, rs[ITERS].sum_x);
      out_y   <= to_coord(fy, rs[ITERS].sum_y);
      out_idx <= rs[ITERS].index;
      m_tlast <= rs[ITERS].last;
    end
  end

  assign m_tdata = {2'b00, out_idx, out_y, out_x};

endmodule

[hw/rtl/cap_checker.sv]
// port level checks for the circle arc point generator
`timescale 1ns / 1ps
module cap_checker
  import cap_pkg::*;
#(
  parameter int POINT_STEPS = 32
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast
);

  localparam logic [IW-1:0] STEPS_I = IW'(POINT_STEPS);

  logic [IW-1:0] exp_idx;

  // expected index of the next output transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_idx <= '0;
    end else if (m_tvalid && m_tready) begin
      exp_idx <= m_tlast ? '0 : exp_idx + IW'(1);
    end
  end

  // points of a run come out in index order
  a_index_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[37:32] == exp_idx)
    else $error("point index out of order");

  // the last flag marks exactly the final index
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[37:32] == STEPS_I)))
    else $error("last flag and index disagree");

  // a stalled point holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output changed");

  // setup takes one input at a time
  a_setup_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while setup busy");

endmodule

bind circle_arc_point_generator cap_checker #(.POINT_STEPS(POINT_STEPS)) u_cap_checker (.*);

[verif/tb_top.sv]
// self-checking testbench for the circle arc point generator
`timescale 1ns / 1ps
module tb_top;
  import cap_pkg::*;

  localparam int STEPS      = 32;
  localparam int WDOG_LIMIT = 20000;
  localparam int MAX_SHOWN  = 10;

  // arctan(2^-k) in 2^-24 turn units, own copy for the predictor
  localparam longint ATAN_REF [20] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
    10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
  };

  typedef struct {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [5:0]         idx;
    logic               last;
  } point_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;   // p_x, p_y, q_x, q_y
  logic [0:0]  s_tuser;   // full_circle
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // point_x, point_y, point_index, zero fill
  logic        m_tlast;   // last_point

  point_t expected_points[$];
  int     mismatches;
  int     idle_cycles;
  int     send_idle_pct;
  int     recv_stall_pct;

  circle_arc_point_generator #(.POINT_STEPS(STEPS)) dut (.*);

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // arithmetic shift right with floor
  function automatic longint shr_floor(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return longint'(res);
  endfunction

  // vectoring cordic, angle in 2^-24 turn
  function automatic longint vector_angle(longint x, longint y);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 8388608 : -8388608;
      x = -x;
      y = -y;
    end
    x = x * (64'sd1 << 20);
    y = y * (64'sd1 << 20);
    for (int k = 0; k < 20; k++) begin
      xs = shr_floor(x, k);
      ys = shr_floor(y, k);
      if (y >= 0) begin
        x += ys; y -= xs; z += ATAN_REF[k];
      end else begin
        x -= ys; y += xs; z -= ATAN_REF[k];
      end
    end
    return z;
  endfunction

  // rotation cordic from (x0, 0) by angle a
  task automatic rotate_vec(input longint a, input longint x0,
                            output longint ox, output longint oy);
    longint x, y, z, xs, ys;
    bit flip;
    x = x0;
    y = 0;
    flip = 0;
    a = a & 64'hFFFFFF;
    if (a >= 4194304 && a < 3 * 4194304) begin
      z = a - 8388608;
      flip = 1;
    end else if (a < 4194304) begin
      z = a;
    end else begin
      z = a - 16777216;
    end
    for (int k = 0; k < 20; k++) begin
      xs = shr_floor(x, k);
      ys = shr_floor(y, k);
      if (z >= 0) begin
        x -= ys; y += xs; z -= ATAN_REF[k];
      end else begin
        x += ys; y -= xs; z += ATAN_REF[k];
      end
    end
    ox = flip ? -x : x;
    oy = flip ? -y : y;
  endtask

  function automatic logic signed [15:0] coord_sat(longint rot, longint sum);
    longint v;
    v = shr_floor(rot + sum * 16384 + 16384, 15);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // works out every point of one run and queues them
  task automatic predict_arc(input logic signed [15:0] p_x, input logic signed [15:0] p_y,
                             input logic signed [15:0] q_x, input logic signed [15:0] q_y,
                             input bit full);
    longint sx, sy, dx, dy, rq, x0, t0, t1, span, a, rx, ry;
    longint unsigned s2;
    point_t pt;
    sx = longint'(p_x) + longint'(q_x);
    sy = longint'(p_y) + longint'(q_y);
    dx = longint'(p_x) - longint'(q_x);
    dy = longint'(p_y) - longint'(q_y);
    s2 = longint'(dx * dx + dy * dy);
    rq = int_sqrt(s2 << 28);
    x0 = (rq * 652032875 + (64'sd1 << 29)) >>> 30;
    t0 = 0;
    span = 0;
    if (!full) begin
      t1 = vector_angle(-dx, -dy);
      t0 = vector_angle(dx, dy);
      span = t1 - t0;
      if (q_y < p_y) t0 += 8388608;
    end
    for (int i = 0; i <= STEPS; i++) begin
      if (full) a = (64'sd1 << 24) * i / STEPS;
      else a = t0 + (span * i) / STEPS;
      rotate_vec(a, x0, rx, ry);
      pt.px = coord_sat(rx, sx);
      pt.py = coord_sat(ry, sy);
      pt.idx = i[5:0];
      pt.last = (i == STEPS);
      expected_points.insert(expected_points.size(), pt);
    end
  endtask

  // sends one transaction and records its points
  task automatic send_pair(input logic [15:0] p_x, input logic [15:0] p_y,
                           input logic [15:0] q_x, input logic [15:0] q_y,
                           input logic full);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {q_y, q_x, p_y, p_x};
    s_tuser  <= full;
    predict_arc(p_x, p_y, q_x, q_y, full);
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_random(input int n);
    logic [15:0] a, b, c, d;
    for (int i = 0; i < n; i++) begin
      a = 16'($urandom);
      b = 16'($urandom);
      // mostly nearby points, sometimes anywhere
      if ($urandom_range(3) == 0) begin
        c = 16'($urandom);
        d = 16'($urandom);
      end else begin
        c = 16'(a + $urandom_range(4095) - 2048);
        d = 16'(b + $urandom_range(4095) - 2048);
      end
      send_pair(a, b, c, d, 1'($urandom_range(1)));
    end
  endtask

  task automatic test_directed();
    send_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);   // coincident at origin
    send_pair(16'h0123, 16'hFF00, 16'h0123, 16'hFF00, 1'b1);   // coincident, full
    send_pair(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 1'b0);   // extreme diameter
    send_pair(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b1);
    send_pair(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b0);
    send_pair(16'h7FFF, 16'h0000, 16'h8000, 16'h0000, 1'b0);   // flat, negative x side
    send_pair(16'h0100, 16'h0000, 16'hFF00, 16'h0000, 1'b1);
    send_pair(16'h0000, 16'h0100, 16'h0000, 16'hFF00, 1'b0);   // q below p
    send_pair(16'h0000, 16'hFF00, 16'h0000, 16'h0100, 1'b0);   // q above p
    send_pair(16'h7FFF, 16'h7FFF, 16'h7F00, 16'h7F00, 1'b1);   // saturating corner
    send_pair(16'hFFFF, 16'hFFFF, 16'h0001, 16'h0001, 1'b0);
    send_pair(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 1'b1);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic test_no_idle();
    send_idle_pct = 0; recv_stall_pct = 0;
    send_random(50);
  endtask

  task automatic test_sender_idle();
    send_idle_pct = 74; recv_stall_pct = 0;
    send_random(50);
  endtask

  task automatic test_receiver_stall();
    send_idle_pct = 0; recv_stall_pct = 74;
    send_random(50);
  endtask

  task automatic test_both_idle();
    send_idle_pct = 14; recv_stall_pct = 14;
    send_random(50);
  endtask

  // receiver ready pattern
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // checks each point against the oldest prediction
  always @(posedge clk) begin
    point_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) $display("unexpected point %h", m_tdata);
      end else begin
        want = expected_points.pop_front();
        if (m_tdata[15:0] !== want.px || m_tdata[31:16] !== want.py ||
            m_tdata[37:32] !== want.idx || m_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("point mismatch: exp x=%h y=%h i=%0d l=%b got x=%h y=%h i=%0d l=%b",
                     want.px, want.py, want.idx, want.last,
                     m_tdata[15:0], m_tdata[31:16], m_tdata[37:32], m_tlast);
        end
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    wait_drained();
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/cap_pkg.sv
hw/rtl/cap_vec_cell.sv
hw/rtl/cap_rot_cell.sv
hw/rtl/cap_setup.sv
hw/rtl/circle_arc_point_generator.sv
hw/rtl/cap_checker.sv
verif/tb_top.sv
